>>> src/dgg_pkg.sv
package dgg_pkg;

	// payload widths
	localparam int CORE_W  = 6;
	localparam int USAGE_W = 15;
	localparam int FREQ_W  = 24;
	localparam int MASK_W  = 64;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_ADDR_W-1:0] REG_GROUP_MASK = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BASE_FREQ  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_TOP_FREQ   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_UP_USAGE   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_DOWN_USAGE = 3'd4;

	// register reset values
	localparam logic [MASK_W-1:0]  RST_GROUP_MASK = 64'd1;
	localparam logic [FREQ_W-1:0]  RST_BASE_FREQ  = 24'd800000;
	localparam logic [FREQ_W-1:0]  RST_TOP_FREQ   = 24'd3000000;
	localparam logic [USAGE_W-1:0] RST_UP_USAGE   = 15'd12800;
	localparam logic [USAGE_W-1:0] RST_DOWN_USAGE = 15'd12800;

	// frequency ladder
	localparam int LADDER_DEPTH = 22;
	localparam int GRADE_W      = $clog2(LADDER_DEPTH);
	localparam int CNT_W        = $clog2(LADDER_DEPTH + 1);
	localparam logic [GRADE_W-1:0] TOP_RUNG = GRADE_W'(LADDER_DEPTH - 1);

	// step = range / 20, done as (range >> 2) / 5 with a reciprocal of 2^20 / 5
	localparam int QUOT_W      = FREQ_W - 2;
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 20;
	localparam int STEP_W      = 20;
	localparam int PROD_W      = QUOT_W + RECIP_W;
	localparam logic [RECIP_W-1:0] DIV5_RECIP = 18'd209715;
	localparam logic [QUOT_W-1:0]  FIVE       = 22'd5;
	localparam logic [STEP_W-1:0]  MIN_STEP   = 20'd50000;

	// usage in 1/256 percent
	localparam logic [USAGE_W-1:0] FULL_USAGE = 15'd25600;
	localparam logic [USAGE_W-1:0] HALF_USAGE = 15'd12800;

	// threshold rung count compares k*A against D*n
	localparam int ACC_W = USAGE_W + GRADE_W;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef struct packed {
		logic build_diff;
		logic build_div;
		logic build_corr;
		logic build_rung;
		logic take;
		logic setup;
		logic count;
		logic apply;
		logic emit;
	} dgg_cmd_t;

	typedef struct packed {
		logic rung_done;
		logic top_zero;
		logic no_move;
		logic count_done;
		logic has_result;
		logic out_free;
	} dgg_sts_t;

endpackage

>>> src/dgg_ram.sv
module dgg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/dgg_ctrl.sv
module dgg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	input  dgg_pkg::dgg_sts_t sts,
	output dgg_pkg::dgg_cmd_t cmd
);

	typedef enum logic [9:0] {
		ST_DIFF  = 10'b0000000001,
		ST_DIV   = 10'b0000000010,
		ST_CORR  = 10'b0000000100,
		ST_RUNG  = 10'b0000001000,
		ST_IDLE  = 10'b0000010000,
		ST_SETUP = 10'b0000100000,
		ST_COUNT = 10'b0001000000,
		ST_APPLY = 10'b0010000000,
		ST_READ  = 10'b0100000000,
		ST_EMIT  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   take;

	assign in_ready = (state_q == ST_IDLE) && !cfg_wen;
	assign take     = in_ready && in_valid;

	always_comb begin
		cmd            = '0;
		cmd.build_diff = (state_q == ST_DIFF);
		cmd.build_div  = (state_q == ST_DIV);
		cmd.build_corr = (state_q == ST_CORR);
		cmd.build_rung = (state_q == ST_RUNG);
		cmd.take       = take;
		cmd.setup      = (state_q == ST_SETUP);
		cmd.count      = (state_q == ST_COUNT);
		cmd.apply      = (state_q == ST_APPLY);
		cmd.emit       = (state_q == ST_EMIT) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_DIFF:  state_d = ST_DIV;
			ST_DIV:   state_d = ST_CORR;
			ST_CORR:  state_d = ST_RUNG;
			ST_RUNG: begin
				if (sts.rung_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (take && in_last) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (sts.top_zero || sts.no_move) state_d = ST_IDLE;
				else state_d = ST_COUNT;
			end
			ST_COUNT: begin
				if (sts.count_done) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				if (sts.has_result) state_d = ST_READ;
				else state_d = ST_IDLE;
			end
			ST_READ:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default:  state_d = ST_DIFF;
		endcase
		// any register write rebuilds the ladder
		if (cfg_wen) state_d = ST_DIFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DIFF;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> src/dgg_dp.sv
module dgg_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dgg_pkg::dgg_cmd_t                 cmd,
	output dgg_pkg::dgg_sts_t                 sts,
	input  logic                              cfg_wen,
	input  logic [dgg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [dgg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic [dgg_pkg::CORE_W-1:0]        in_core,
	input  logic [dgg_pkg::USAGE_W-1:0]       in_usage,
	input  logic                              in_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dgg_pkg::FREQ_W-1:0]        out_freq,
	output logic [dgg_pkg::GRADE_W-1:0]       out_grade
);

	// configuration registers
	logic [dgg_pkg::MASK_W-1:0]  mask_q;
	logic [dgg_pkg::FREQ_W-1:0]  base_q, top_q;
	logic [dgg_pkg::USAGE_W-1:0] up_q, down_q;

	// ladder build
	logic [dgg_pkg::FREQ_W-1:0]  diff_q;
	logic [dgg_pkg::USAGE_W-1:0] upv_q, dnv_q;
	logic [dgg_pkg::PROD_W-1:0]  recip_q;
	logic [dgg_pkg::STEP_W-1:0]  step_q;
	logic [dgg_pkg::FREQ_W:0]    rung_f_q;
	logic [dgg_pkg::GRADE_W-1:0] top_grade_q;

	// decision
	logic [dgg_pkg::USAGE_W-1:0] max_q, mx_q, a_q;
	logic [dgg_pkg::ACC_W-1:0]   dn_q, acc_q;
	logic [dgg_pkg::GRADE_W-1:0] k_q, grade_q;
	logic [dgg_pkg::CNT_W-1:0]   cnt_q;
	logic                        up_mode_q;
	dgg_pkg::dir_t               dir_q;

	// output register
	logic                        out_valid_q;
	logic [dgg_pkg::FREQ_W-1:0]  out_freq_q;
	logic [dgg_pkg::GRADE_W-1:0] out_grade_q;

	logic [dgg_pkg::USAGE_W-1:0] up_eff, dn_eff, new_max, d_val;
	logic [dgg_pkg::STEP_W-1:0]  q0, q_fix;
	logic [dgg_pkg::QUOT_W-1:0]  rem;
	logic                        rung_go, go_up, go_dn, move_up, move_dn;
	logic [dgg_pkg::ACC_W-1:0]   d_times_n;
	logic [dgg_pkg::CNT_W:0]     up_sum, top_ext, cnt_ext, grade_ext;
	logic [dgg_pkg::GRADE_W-1:0] up_grade, dn_grade;
	logic [dgg_pkg::FREQ_W-1:0]  rung_wdata, ram_rdata;

	// effective thresholds
	always_comb begin
		if (up_q == '0 || up_q > dgg_pkg::FULL_USAGE) up_eff = dgg_pkg::HALF_USAGE;
		else up_eff = up_q;
		if (down_q == '0 || down_q > up_eff) begin
			dn_eff = (up_eff < dgg_pkg::HALF_USAGE) ? up_eff : dgg_pkg::HALF_USAGE;
		end else begin
			dn_eff = down_q;
		end
	end

	// range / 20 with a one-step correction
	assign q0    = recip_q[dgg_pkg::RECIP_SHIFT +: dgg_pkg::STEP_W];
	assign rem   = diff_q[dgg_pkg::FREQ_W-1:2]
		- (dgg_pkg::QUOT_W'({q0, 2'b00}) + dgg_pkg::QUOT_W'(q0));
	assign q_fix = q0 + dgg_pkg::STEP_W'(rem >= dgg_pkg::FIVE);

	assign rung_go    = (rung_f_q < {1'b0, top_q}) && (top_grade_q < dgg_pkg::TOP_RUNG);
	assign rung_wdata = rung_go ? rung_f_q[dgg_pkg::FREQ_W-1:0] : top_q;

	// running maximum over samples of the group
	assign new_max = (mask_q[in_core] && in_usage > max_q) ? in_usage : max_q;

	// decision mode
	assign go_up     = (dir_q != dgg_pkg::DIR_UP) && (mx_q > upv_q);
	assign go_dn     = !go_up && (dir_q != dgg_pkg::DIR_DOWN) && (mx_q < dnv_q);
	assign d_val     = go_up ? (mx_q - upv_q) : (dnv_q - mx_q);
	assign d_times_n = dgg_pkg::ACC_W'(d_val) * dgg_pkg::ACC_W'(top_grade_q);

	// grade update
	assign grade_ext = (dgg_pkg::CNT_W+1)'(grade_q);
	assign cnt_ext   = (dgg_pkg::CNT_W+1)'(cnt_q);
	assign top_ext   = (dgg_pkg::CNT_W+1)'(top_grade_q);
	assign up_sum    = grade_ext + cnt_ext;
	assign up_grade  = (up_sum > top_ext) ? top_grade_q : dgg_pkg::GRADE_W'(up_sum);
	assign dn_grade  = (cnt_ext >= grade_ext) ? '0 : grade_q - dgg_pkg::GRADE_W'(cnt_q);
	assign move_up   = up_mode_q && (cnt_q != '0) && (grade_q < top_grade_q);
	assign move_dn   = !up_mode_q && (cnt_q != '0) && (grade_q != '0);

	always_comb begin
		sts            = '0;
		sts.rung_done  = !rung_go;
		sts.top_zero   = (top_grade_q == '0);
		sts.no_move    = !go_up && !go_dn;
		sts.count_done = (k_q == top_grade_q);
		sts.has_result = move_up || move_dn || (dir_q != dgg_pkg::DIR_NONE);
		sts.out_free   = !out_valid_q || out_ready;
	end

	dgg_ram #(
		.WIDTH(dgg_pkg::FREQ_W),
		.DEPTH(dgg_pkg::LADDER_DEPTH)
	) u_freq_ladder (
		.clk  (clk),
		.we   (cmd.build_rung),
		.waddr(top_grade_q),
		.wdata(rung_wdata),
		.raddr(grade_q),
		.rdata(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= dgg_pkg::RST_GROUP_MASK;
			base_q <= dgg_pkg::RST_BASE_FREQ;
			top_q  <= dgg_pkg::RST_TOP_FREQ;
			up_q   <= dgg_pkg::RST_UP_USAGE;
			down_q <= dgg_pkg::RST_DOWN_USAGE;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				dgg_pkg::REG_GROUP_MASK: mask_q <= cfg_wdata;
				dgg_pkg::REG_BASE_FREQ:  base_q <= cfg_wdata[dgg_pkg::FREQ_W-1:0];
				dgg_pkg::REG_TOP_FREQ:   top_q  <= cfg_wdata[dgg_pkg::FREQ_W-1:0];
				dgg_pkg::REG_UP_USAGE:   up_q   <= cfg_wdata[dgg_pkg::USAGE_W-1:0];
				dgg_pkg::REG_DOWN_USAGE: down_q <= cfg_wdata[dgg_pkg::USAGE_W-1:0];
				default: ;
			endcase
		end
	end

	// ladder build datapath
	always_ff @(posedge clk) begin
		if (cmd.build_diff) begin
			diff_q <= (top_q > base_q) ? (top_q - base_q) : '0;
			upv_q  <= up_eff;
			dnv_q  <= dn_eff;
		end
		if (cmd.build_div) begin
			recip_q <= dgg_pkg::PROD_W'(diff_q[dgg_pkg::FREQ_W-1:2])
				* dgg_pkg::PROD_W'(dgg_pkg::DIV5_RECIP);
		end
		if (cmd.build_corr) begin
			step_q   <= (q_fix < dgg_pkg::MIN_STEP) ? dgg_pkg::MIN_STEP : q_fix;
			rung_f_q <= {1'b0, base_q};
		end else if (cmd.build_rung && rung_go) begin
			rung_f_q <= rung_f_q + (dgg_pkg::FREQ_W+1)'(step_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_grade_q <= '0;
		end else if (cmd.build_corr) begin
			top_grade_q <= '0;
		end else if (cmd.build_rung && rung_go) begin
			top_grade_q <= top_grade_q + dgg_pkg::GRADE_W'(1);
		end
	end

	// rung count loop
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			up_mode_q <= go_up;
			a_q       <= go_up ? (dgg_pkg::FULL_USAGE - upv_q) : dnv_q;
			dn_q      <= d_times_n;
			acc_q     <= '0;
			k_q       <= '0;
			cnt_q     <= '0;
		end else if (cmd.count) begin
			if (acc_q < dn_q) cnt_q <= cnt_q + dgg_pkg::CNT_W'(1);
			acc_q <= acc_q + dgg_pkg::ACC_W'(a_q);
			k_q   <= k_q + dgg_pkg::GRADE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && in_last) mx_q <= new_max;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= '0;
			grade_q <= '0;
			dir_q   <= dgg_pkg::DIR_NONE;
		end else begin
			if (cmd.take) max_q <= in_last ? '0 : new_max;
			if (cmd.setup && !sts.top_zero && sts.no_move) dir_q <= dgg_pkg::DIR_NONE;
			if (cmd.apply) begin
				if (move_up) begin
					grade_q <= up_grade;
					dir_q   <= dgg_pkg::DIR_UP;
				end else if (move_dn) begin
					grade_q <= dn_grade;
					dir_q   <= dgg_pkg::DIR_DOWN;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_freq_q  <= ram_rdata;
			out_grade_q <= grade_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_freq  = out_freq_q;
	assign out_grade = out_grade_q;

endmodule

>>> src/dvfs_grade_governor_unit.sv
// channel    | direction | handshake                    | payload
// -----------+-----------+------------------------------+--------------------------------
// s_axis     | in        | s_axis_tvalid, s_axis_tready | tdata: core_index, usage; tlast
// m_axis     | out       | m_axis_tvalid, m_axis_tready | tdata: freq_cap_khz, grade_index
// cfg        | in        | cfg_wen (no wait)            | cfg_addr, cfg_wdata
//
// a sample without tlast is taken and intake stays open; a sample with tlast runs the decision
// sequencer (setup, rung count loop, apply, read, emit), the rung count loop testing the rungs in turn
// after reset and after each register write the frequency ladder is rebuilt rung by
// rung into the ladder memory, with s_axis_tready low
// the result register lets the last result wait while new samples are taken; a
// decision that has a result waits for the result register to free up
module dvfs_grade_governor_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// register write port
	input  logic                           cfg_wen,
	input  logic [dgg_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [dgg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// usage samples
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [23:0]                    s_axis_tdata,  // [5:0] core_index, [20:6] usage
	input  logic                           s_axis_tlast,
	// frequency cap results
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [31:0]                    m_axis_tdata   // [23:0] freq_cap_khz, [28:24] grade_index
);

	dgg_pkg::dgg_cmd_t cmd;
	dgg_pkg::dgg_sts_t sts;

	logic [dgg_pkg::FREQ_W-1:0]  freq_cap_khz;
	logic [dgg_pkg::GRADE_W-1:0] grade_index;

	// sequencer: ladder rebuild, sample intake, decision steps
	dgg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wen (cfg_wen),
		.in_valid(s_axis_tvalid),
		.in_last (s_axis_tlast),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// registers, ladder memory, period maximum, grade and result register
	dgg_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_wen  (cfg_wen),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_core  (s_axis_tdata[5:0]),
		.in_usage (s_axis_tdata[20:6]),
		.in_last  (s_axis_tlast),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_freq (freq_cap_khz),
		.out_grade(grade_index)
	);

	// pack result, spare bits zero
	assign m_axis_tdata = {3'b000, grade_index, freq_cap_khz};

	// a register write always restarts the ladder build
	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |=> !s_axis_tready)
		else $error("sample intake open right after a register write");

	// a new result only appears after the load step
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.emit))
		else $error("result appeared without a load");

	// reported grade stays on the ladder
	a_grade_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (grade_index <= dgg_pkg::TOP_RUNG))
		else $error("grade beyond the top rung");

	// no sample is taken during the rung count loop or the apply step
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.count || cmd.apply) |-> !s_axis_tready)
		else $error("sample taken during a decision");

endmodule
